/* design/sector_pattern_gen_check_defines.svh */
// ----------------------------------------------------------------------------
// Sector pattern generator/checker assertion macros
// Shared concurrent assertion forms used by the sector pattern engine.
// ----------------------------------------------------------------------------
`ifndef SECTOR_PATTERN_GEN_CHECK_DEFINES_SVH
`define SECTOR_PATTERN_GEN_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sector pattern engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sector pattern engine: next-cycle check failed");

`endif

/* design/sgc_pkg.sv */
// ----------------------------------------------------------------------------
// Sector pattern engine package
// Widths, register indexes and defaults shared by the sector pattern engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sgc_pkg;

    localparam int WORD_W               = 64;
    localparam int COUNT_W              = 32;
    localparam int CFG_IDX_W            = 1;
    localparam int CFG_DATA_W           = 64;
    localparam int SLICES_PER_SECTOR_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ITER = 1'd1;

    localparam logic [COUNT_W-1:0] BAD_MAX = {COUNT_W{1'b1}};

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

`default_nettype wire

/* design/sgc_in_if.sv */
// ----------------------------------------------------------------------------
// Sector pattern engine input channel
// Carries one slice read back from the disk: sector word and iteration word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgc_in_if;

    logic          valid;
    logic          ready;
    sgc_pkg::t_word read_sector_id;
    sgc_pkg::t_word read_iteration;

    modport source (output valid, output read_sector_id, output read_iteration,
                    input ready);
    modport sink (input valid, input read_sector_id, input read_iteration,
                  output ready);

endinterface

`default_nettype wire

/* design/sgc_out_if.sv */
// ----------------------------------------------------------------------------
// Sector pattern engine result channel
// Carries the expected slice, the mismatch flags and the bad sector count.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgc_out_if;

    logic            valid;
    logic            ready;
    sgc_pkg::t_word  pattern_sector_id;
    sgc_pkg::t_word  pattern_iteration;
    logic            slice_mismatch;
    logic            sector_end;
    logic            sector_bad;
    sgc_pkg::t_count bad_sector_total;

    modport source (output valid, output pattern_sector_id, output pattern_iteration,
                    output slice_mismatch, output sector_end, output sector_bad,
                    output bad_sector_total, input ready);
    modport sink (input valid, input pattern_sector_id, input pattern_iteration,
                  input slice_mismatch, input sector_end, input sector_bad,
                  input bad_sector_total, output ready);

endinterface

`default_nettype wire

/* design/sector_pattern_gen_check.sv */
// ----------------------------------------------------------------------------
// Sector pattern generator/checker
// Address-in-data test pattern engine: one slice per transfer, sector and
// iteration counters, sticky per-sector error and saturating bad count.
// ----------------------------------------------------------------------------
// The block takes one slice per clock while the result channel is not stalled
// and returns one result per slice: the slice is captured in an input register,
// and the compare plus the counter updates run as it moves into the result
// register. Both stages advance whenever the result register is empty or its
// transfer completes, so the throughput is one slice per cycle and is set by
// the 64-bit compare and increment path. Configuration writes should be made
// only while no slice is in flight; a write of the start iteration also
// reloads the running iteration counter.
`default_nettype none

`include "sector_pattern_gen_check_defines.svh"

module sector_pattern_gen_check #(
    parameter int SLICES_PER_SECTOR = sgc_pkg::SLICES_PER_SECTOR_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [sgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [sgc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sgc_in_if.sink                             i_in,
    sgc_out_if.source                          o_out
);

    localparam int IDX_W = (SLICES_PER_SECTOR > 1) ? $clog2(SLICES_PER_SECTOR) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLICES_PER_SECTOR - 1);

    logic             r_check_mode;
    sgc_pkg::t_word   r_sector_counter;
    sgc_pkg::t_word   r_iteration_counter;
    logic [IDX_W-1:0] r_slice_index;
    logic             r_error_flag;
    sgc_pkg::t_count  r_bad_count;

    logic             r_in_valid;
    sgc_pkg::t_word   r_in_sector_id;
    sgc_pkg::t_word   r_in_iteration;

    logic             r_out_valid;
    sgc_pkg::t_word   r_out_sector_id;
    sgc_pkg::t_word   r_out_iteration;
    logic             r_out_mismatch;
    logic             r_out_end;
    logic             r_out_bad;

    logic             out_load;
    logic             in_load;
    logic             n_mismatch;
    logic             n_last;
    logic             n_bad;
    sgc_pkg::t_count  n_bad_count;

    assign out_load   = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_load    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || !r_out_valid || o_out.ready;

    always_comb begin
        n_mismatch = r_check_mode && ((r_in_sector_id != r_sector_counter) ||
                                      (r_in_iteration != r_iteration_counter));
        n_last     = (r_slice_index >= LAST_IDX);
        n_bad      = n_last && (r_error_flag || n_mismatch);
        if (n_bad && (r_bad_count != sgc_pkg::BAD_MAX)) begin
            n_bad_count = r_bad_count + 1'b1;
        end else begin
            n_bad_count = r_bad_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode        <= 1'b0;
            r_sector_counter    <= '0;
            r_iteration_counter <= '0;
            r_slice_index       <= '0;
            r_error_flag        <= 1'b0;
            r_bad_count         <= '0;
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sgc_pkg::REG_CHECK_MODE: r_check_mode <= i_cfg_data[0];
                    sgc_pkg::REG_START_ITER: r_iteration_counter <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_load) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid         <= 1'b1;
                r_iteration_counter <= r_iteration_counter + 1'b1;
                r_bad_count         <= n_bad_count;
                if (n_last) begin
                    r_sector_counter <= r_sector_counter + 1'b1;
                    r_error_flag     <= 1'b0;
                    r_slice_index    <= '0;
                end else begin
                    r_error_flag     <= r_error_flag || n_mismatch;
                    r_slice_index    <= r_slice_index + 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_sector_id <= i_in.read_sector_id;
            r_in_iteration <= i_in.read_iteration;
        end
        if (out_load) begin
            r_out_sector_id <= r_sector_counter;
            r_out_iteration <= r_iteration_counter;
            r_out_mismatch  <= n_mismatch;
            r_out_end       <= n_last;
            r_out_bad       <= n_bad;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.pattern_sector_id = r_out_sector_id;
    assign o_out.pattern_iteration = r_out_iteration;
    assign o_out.slice_mismatch    = r_out_mismatch;
    assign o_out.sector_end        = r_out_end;
    assign o_out.sector_bad        = r_out_bad;
    assign o_out.bad_sector_total  = r_bad_count;

    `SGC_ASSERT_SAME(a_bad_only_at_end, i_clk, i_rst_n, r_out_valid && r_out_bad, r_out_end)
    `SGC_ASSERT_SAME(a_index_in_range, i_clk, i_rst_n, 1'b1, r_slice_index <= LAST_IDX)
    `SGC_ASSERT_NEXT(a_count_monotonic, i_clk, i_rst_n, 1'b1, r_bad_count >= $past(r_bad_count))

endmodule

`default_nettype wire
